>>> src/modular_inverse_ext_euclid_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular inverse core
// Shared property forms used by the checker of the core.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_CORE_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_CORE_ASSERT_SVH

// A stalled channel keeps its valid high and its payload steady.
`define MIE_ASSERT_HOLD(lbl, clk, rst, vld, rdy, payload) \
   lbl: assert property (@(posedge clk) disable iff (rst) \
      (vld && !rdy) |=> (vld && $stable(payload))) \
      else $error("stalled item changed or was dropped");

// Same-cycle implication.
`define MIE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// Next-cycle implication.
`define MIE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> src/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// Shared constants and types of the modular inverse core.
// ----------------------------------------------------------------------------
package mie_pkg;

   localparam int WIDTH_DEF = 31;

   // Reset value of the modulus register, truncated to the field width.
   localparam logic [63:0] MOD_RESET = 64'h0000_0000_7fff_ffff;

   // Status of the shared subtract and compare unit.
   typedef struct packed {
      logic ge;        // remainder is at least the divisor
      logic up_ok;     // doubled divisor still fits under the remainder
      logic div_zero;  // divisor is zero
   } mie_step_flags_type;

endpackage

>>> src/mie_step_unit.sv
// ----------------------------------------------------------------------------
// mie_step_unit
// Shared compare and subtract unit: one restoring division step on the
// remainder and, in parallel, the matching update of the Bezout coefficient.
// ----------------------------------------------------------------------------
module mie_step_unit #(
   parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
   input  logic [WIDTH-1:0]          rem,
   input  logic [WIDTH-1:0]          div,
   input  logic signed [WIDTH+1:0]   coef,
   input  logic signed [WIDTH+1:0]   coef_step,
   output logic [WIDTH-1:0]          rem_sub,
   output logic signed [WIDTH+1:0]   coef_sub,
   output mie_pkg::mie_step_flags_type flags
);

   assign rem_sub        = rem - div;
   assign coef_sub       = coef - coef_step;
   assign flags.ge       = (rem >= div);
   assign flags.up_ok    = ({div, 1'b0} <= {1'b0, rem});
   assign flags.div_zero = (div == '0);

endmodule

>>> src/modular_inverse_ext_euclid_core.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_core
// Extended Euclidean modular inverse against a configured modulus.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_ready  | req_value
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_inverse, rsp_gcd_value,
//           |           |                      | rsp_not_invertible
//   csr     | in        | csr_valid/csr_ready  | csr_data (modulus)
//
// Each Euclid step doubles the divisor in S_UP while it still fits under the
// remainder, then subtracts and halves it in S_SUB on the shared subtract and
// compare unit; S_NEG and S_RED then reduce the coefficient to the inverse.
// One item is in flight at a time; req_ready is high only in the idle state.
// A finished result waits in the output register, so the next item can be
// taken while rsp_ready is low. Reset is synchronous and sets the modulus
// to its default.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_core #(
   parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [WIDTH-1:0] req_value,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic [WIDTH-1:0] rsp_gcd_value,
   output logic             rsp_not_invertible,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [WIDTH-1:0] csr_data
);

   localparam int CW = WIDTH + 2;
   localparam int KW = $clog2(WIDTH);
   localparam logic [WIDTH-1:0] MOD_RST = WIDTH'(mie_pkg::MOD_RESET);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_UP   = 6'b000010,
      S_SUB  = 6'b000100,
      S_NEG  = 6'b001000,
      S_RED  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [WIDTH-1:0]        rem_ff, rem_in;
   logic [WIDTH-1:0]        r_ff, r_in;
   logic [WIDTH-1:0]        d_ff, d_in;
   logic signed [CW-1:0]    sacc_ff, sacc_in;
   logic signed [CW-1:0]    s_ff, s_in;
   logic signed [CW-1:0]    ssh_ff, ssh_in;
   logic                    neg_ff, neg_in;
   logic [WIDTH-1:0]        mod_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]        inv_ff, inv_in;
   logic [WIDTH-1:0]        gcd_ff, gcd_in;
   logic                    flag_ff, flag_in;

   logic [WIDTH-1:0]        unit_rem, unit_div, unit_rem_sub;
   logic signed [CW-1:0]    unit_coef_sub;
   logic signed [CW-1:0]    sacc_neg;
   logic [WIDTH-1:0]        rem_next;
   logic signed [CW-1:0]    sacc_next;
   logic                    out_load;
   mie_pkg::mie_step_flags_type flags;

   // During the final reduction the unit compares the magnitude with the
   // modulus; otherwise it works on the remainder and the shifted divisor.
   assign unit_rem = (state_ff == S_RED) ? d_ff   : rem_ff;
   assign unit_div = (state_ff == S_RED) ? mod_ff : d_ff;

   mie_step_unit #(.WIDTH(WIDTH)) u_step (
      .rem       (unit_rem),
      .div       (unit_div),
      .coef      (sacc_ff),
      .coef_step (ssh_ff),
      .rem_sub   (unit_rem_sub),
      .coef_sub  (unit_coef_sub),
      .flags     (flags)
   );

   assign sacc_neg  = -sacc_ff;
   assign rem_next  = flags.ge ? unit_rem_sub  : rem_ff;
   assign sacc_next = flags.ge ? unit_coef_sub : sacc_ff;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      rem_in   = rem_ff;
      r_in     = r_ff;
      d_in     = d_ff;
      sacc_in  = sacc_ff;
      s_in     = s_ff;
      ssh_in   = ssh_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rem_in   = mod_ff;
               r_in     = req_value;
               d_in     = req_value;
               sacc_in  = '0;
               s_in     = CW'(1);
               ssh_in   = CW'(1);
               k_in     = '0;
               state_in = S_UP;
            end
         end
         S_UP: begin
            // The divisor is zero only before any shift, when Euclid is done.
            if (flags.div_zero) begin
               state_in = S_NEG;
            end else if (flags.up_ok) begin
               d_in   = {d_ff[WIDTH-2:0], 1'b0};
               ssh_in = {ssh_ff[CW-2:0], 1'b0};
               k_in   = k_ff + KW'(1);
            end else begin
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            if (k_ff == '0) begin
               // Last quotient bit: rotate the remainder and coefficient pairs.
               rem_in   = r_ff;
               r_in     = rem_next;
               d_in     = rem_next;
               sacc_in  = s_ff;
               s_in     = sacc_next;
               ssh_in   = sacc_next;
               state_in = S_UP;
            end else begin
               rem_in  = rem_next;
               sacc_in = sacc_next;
               d_in    = {1'b0, d_ff[WIDTH-1:1]};
               ssh_in  = ssh_ff >>> 1;
               k_in    = k_ff - KW'(1);
            end
         end
         S_NEG: begin
            neg_in = sacc_ff[CW-1];
            d_in   = sacc_ff[CW-1] ? sacc_neg[WIDTH-1:0] : sacc_ff[WIDTH-1:0];
            state_in = S_RED;
         end
         S_RED: begin
            if (flags.ge) begin
               d_in = unit_rem_sub;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      inv_in       = inv_ff;
      gcd_in       = gcd_ff;
      flag_in      = flag_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         gcd_in       = rem_ff;
         if (mod_ff == '0) begin
            inv_in  = '0;
            flag_in = 1'b1;
         end else begin
            inv_in  = (neg_ff && (d_ff != '0)) ? (mod_ff - d_ff) : d_ff;
            flag_in = (rem_ff != WIDTH'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= MOD_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            mod_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      rem_ff  <= rem_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      sacc_ff <= sacc_in;
      s_ff    <= s_in;
      ssh_ff  <= ssh_in;
      neg_ff  <= neg_in;
      inv_ff  <= inv_in;
      gcd_ff  <= gcd_in;
      flag_ff <= flag_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_inverse        = inv_ff;
   assign rsp_gcd_value      = gcd_ff;
   assign rsp_not_invertible = flag_ff;

endmodule

>>> src/mie_checker.sv
// ----------------------------------------------------------------------------
// mie_checker
// Port-level checks of the modular inverse core, bound to the top level.
// ----------------------------------------------------------------------------
`include "modular_inverse_ext_euclid_core_assert.svh"

module mie_checker #(
   parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [WIDTH-1:0] rsp_inverse,
   input logic [WIDTH-1:0] rsp_gcd_value,
   input logic             rsp_not_invertible
);

   logic [2*WIDTH:0] rsp_payload;
   logic             gcd_is_one;
   logic             gcd_is_zero;

   assign rsp_payload = {rsp_inverse, rsp_gcd_value, rsp_not_invertible};
   assign gcd_is_one  = (rsp_gcd_value == WIDTH'(1));
   assign gcd_is_zero = (rsp_gcd_value == '0);

   // A result held back by the consumer must not change.
   `MIE_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid, rsp_ready, rsp_payload)

   // Once an item is taken the core is busy for at least the next cycle.
   `MIE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // A clear flag means the gcd really is one.
   `MIE_ASSERT_IMP(a_flag_gcd, clock, reset, rsp_valid && !rsp_not_invertible, gcd_is_one)

   // A gcd of zero can only come with the flag set.
   `MIE_ASSERT_IMP(a_zero_gcd, clock, reset, rsp_valid && gcd_is_zero, rsp_not_invertible)

endmodule

bind modular_inverse_ext_euclid_core mie_checker #(.WIDTH(WIDTH)) u_mie_checker (.*);
